@@ src/spv_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package spv_pkg;

	// history geometry
	localparam int HIST_DEPTH = 16;
	localparam int BIN_BITS   = 12;
	localparam int HIST_AW    = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
	localparam int CNT_W      = $clog2(HIST_DEPTH + 1);

	// port widths
	localparam int BIN_IN_BITS  = 12;
	localparam int AMP_BITS     = 24;
	localparam int TOL_BITS     = 12;
	localparam int AGREE_BITS   = 7;
	localparam int CFG_IDX_BITS = 2;
	localparam int CFG_DAT_BITS = 24;
	localparam int CMP_W        = (BIN_BITS > TOL_BITS) ? BIN_BITS : TOL_BITS;

	// configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] CFG_THRESHOLD = CFG_IDX_BITS'(0);
	localparam logic [CFG_IDX_BITS-1:0] CFG_TOLERANCE = CFG_IDX_BITS'(1);

	// register reset values
	localparam logic [AMP_BITS-1:0] THRESHOLD_RST = AMP_BITS'(459);
	localparam logic [TOL_BITS-1:0] TOLERANCE_RST = TOL_BITS'(3);

	// read request from the vote sequencer to the history memory
	typedef struct packed {
		logic [HIST_AW-1:0] addr_a;
		logic [HIST_AW-1:0] addr_b;
	} spv_rd_req_t;

	// vote result
	typedef struct packed {
		logic                done;
		logic                busy;
		logic [BIN_BITS-1:0] bin;
		logic [CNT_W-1:0]    count;
	} spv_vote_res_t;

endpackage

`default_nettype wire

@@ src/spv_peak_trk.sv @@
`timescale 1ns / 1ps
`default_nettype none

module spv_peak_trk import spv_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                accept,
	input  wire logic [BIN_BITS-1:0] bin,
	input  wire logic [AMP_BITS-1:0] amp,
	input  wire logic                last,
	input  wire logic [AMP_BITS-1:0] threshold,
	output logic      [BIN_BITS-1:0] peak
);

	logic [BIN_BITS-1:0] bin_q;
	logic [AMP_BITS-1:0] level_q;
	logic                started_q;

	// advance the running maximum; the first bin of a frame seeds it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_q     <= '0;
			level_q   <= '0;
			started_q <= 1'b0;
		end else if (accept) begin
			if (!started_q || (amp > level_q)) begin
				bin_q   <= bin;
				level_q <= amp;
			end
			started_q <= !last;
		end
	end

	// drop a peak below threshold to bin zero
	assign peak = (level_q < threshold) ? '0 : bin_q;

endmodule

`default_nettype wire

@@ src/spv_hist_mem.sv @@
`timescale 1ns / 1ps
`default_nettype none

module spv_hist_mem import spv_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                wr_en,
	input  wire logic [HIST_AW-1:0]  wr_addr,
	input  wire logic [BIN_BITS-1:0] wr_data,
	input  wire spv_rd_req_t         rd_req,
	output logic      [BIN_BITS-1:0] rd_data_a,
	output logic      [BIN_BITS-1:0] rd_data_b
);

	logic [BIN_BITS-1:0]   mem [HIST_DEPTH];
	logic [HIST_DEPTH-1:0] valid_q;

	// mark entries once written; unwritten entries read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	// write port and two registered read ports
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_a <= valid_q[rd_req.addr_a] ? mem[rd_req.addr_a] : '0;
		rd_data_b <= valid_q[rd_req.addr_b] ? mem[rd_req.addr_b] : '0;
	end

endmodule

`default_nettype wire

@@ src/spv_vote_seq.sv @@
`timescale 1ns / 1ps
`default_nettype none

module spv_vote_seq import spv_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [HIST_AW-1:0]  base,
	input  wire logic [TOL_BITS-1:0] tolerance,
	output spv_rd_req_t              rd_req,
	input  wire logic [BIN_BITS-1:0] rd_data_a,
	input  wire logic [BIN_BITS-1:0] rd_data_b,
	output spv_vote_res_t            res
);

	localparam logic [HIST_AW-1:0] LAST_ADDR = HIST_AW'(HIST_DEPTH - 1);

	logic               run_q;
	logic [HIST_AW-1:0] pa_q;
	logic [HIST_AW-1:0] ia_q;
	logic [HIST_AW-1:0] ib_q;
	logic               iss_s1;
	logic               end_row_s1;
	logic               end_all_s1;
	logic [CNT_W-1:0]   n_q;
	logic [CNT_W-1:0]   best_cnt_q;
	logic [BIN_BITS-1:0] best_bin_q;
	logic               done_q;

	logic                ib_last;
	logic                ia_last;
	logic [BIN_BITS-1:0] diff;
	logic                agree;
	logic [CNT_W-1:0]    n_next;

	assign ib_last = (ib_q == LAST_ADDR);
	assign ia_last = (ia_q == LAST_ADDR);

	assign rd_req.addr_a = pa_q;
	assign rd_req.addr_b = ib_q;

	// compare one pair of entries read in the previous cycle
	always_comb begin
		diff   = (rd_data_a > rd_data_b) ? (rd_data_a - rd_data_b) : (rd_data_b - rd_data_a);
		agree  = (CMP_W'(diff) < CMP_W'(tolerance));
		n_next = n_q + CNT_W'(agree);
	end

	// issue every (candidate, entry) pair, candidates oldest first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q      <= 1'b0;
			pa_q       <= '0;
			ia_q       <= '0;
			ib_q       <= '0;
			iss_s1     <= 1'b0;
			end_row_s1 <= 1'b0;
			end_all_s1 <= 1'b0;
		end else begin
			iss_s1     <= run_q;
			end_row_s1 <= run_q && ib_last;
			end_all_s1 <= run_q && ib_last && ia_last;
			if (start) begin
				run_q <= 1'b1;
				pa_q  <= base;
				ia_q  <= '0;
				ib_q  <= '0;
			end else if (run_q) begin
				if (ib_last) begin
					ib_q <= '0;
					ia_q <= ia_q + HIST_AW'(1);
					pa_q <= (pa_q == LAST_ADDR) ? '0 : (pa_q + HIST_AW'(1));
					if (ia_last) begin
						run_q <= 1'b0;
					end
				end else begin
					ib_q <= ib_q + HIST_AW'(1);
				end
			end
		end
	end

	// count agreements per candidate and keep the strictly better one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q        <= '0;
			best_cnt_q <= '0;
			best_bin_q <= '0;
			done_q     <= 1'b0;
		end else begin
			done_q <= iss_s1 && end_all_s1;
			if (start) begin
				n_q        <= '0;
				best_cnt_q <= '0;
				best_bin_q <= '0;
			end else if (iss_s1) begin
				if (end_row_s1) begin
					n_q <= '0;
					if (n_next > best_cnt_q) begin
						best_cnt_q <= n_next;
						best_bin_q <= rd_data_a;
					end
				end else begin
					n_q <= n_next;
				end
			end
		end
	end

	assign res.done  = done_q;
	assign res.busy  = run_q || iss_s1;
	assign res.bin   = best_bin_q;
	assign res.count = best_cnt_q;

endmodule

`default_nettype wire

@@ src/spectral_peak_pitch_voter.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Spectral peak picker with a pitch vote over recent frames. Bins of one frame
// arrive one per request, the last one marked; a bin that is not the last is
// taken with no stall. The last bin closes the frame: its peak (bin 0 when below
// amplitude_threshold) goes into a 16-entry history memory, and a vote then
// counts, for each history entry, how many entries lie closer than
// bin_tolerance. One pair is compared per cycle through the two read ports of
// the history memory, and a closing bin holds the input stalled until the
// result (peak_bin, consensus_bin, agree_count) is registered at the output.
// Ties in the vote go to the oldest entry. The history reads as zeros after
// reset; no clearing pass is needed. Configuration writes are always taken
// (cfg_ready is high) and belong in idle periods.
module spectral_peak_pitch_voter import spv_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	// configuration
	input  wire logic                    cfg_valid,
	output logic                         cfg_ready,
	input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
	input  wire logic [CFG_DAT_BITS-1:0] cfg_data,
	// bin requests
	input  wire logic                    in_valid,
	output logic                         in_stall,
	input  wire logic [BIN_IN_BITS-1:0]  bin_index,
	input  wire logic [AMP_BITS-1:0]     amplitude,
	input  wire logic                    last_bin,
	// frame results
	output logic                         out_valid,
	input  wire logic                    out_stall,
	output logic      [BIN_IN_BITS-1:0]  peak_bin,
	output logic      [BIN_IN_BITS-1:0]  consensus_bin,
	output logic      [AGREE_BITS-1:0]   agree_count
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CLOSE,
		ST_VOTE
	} state_t;

	localparam logic [HIST_AW-1:0] LAST_ADDR = HIST_AW'(HIST_DEPTH - 1);

	state_t              state_q;
	logic [AMP_BITS-1:0] threshold_q;
	logic [TOL_BITS-1:0] tolerance_q;
	logic [HIST_AW-1:0]  wp_q;
	logic [HIST_AW-1:0]  wp_next;
	logic [BIN_BITS-1:0] peak_q;
	logic                res_ready_q;
	logic                out_valid_q;

	logic                in_accept;
	logic                cfg_accept;
	logic [BIN_BITS-1:0] trk_peak;
	logic                hist_wr;
	logic                vote_start;
	spv_rd_req_t         rd_req;
	logic [BIN_BITS-1:0] rd_data_a;
	logic [BIN_BITS-1:0] rd_data_b;
	spv_vote_res_t       vote_res;

	assign cfg_ready  = 1'b1;
	assign cfg_accept = cfg_valid && cfg_ready;
	assign in_stall   = (state_q != ST_IDLE);
	assign in_accept  = in_valid && !in_stall;
	assign out_valid  = out_valid_q;

	assign hist_wr    = (state_q == ST_CLOSE);
	assign vote_start = (state_q == ST_CLOSE);
	assign wp_next    = (wp_q == LAST_ADDR) ? '0 : (wp_q + HIST_AW'(1));

	// hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RST;
			tolerance_q <= TOLERANCE_RST;
		end else if (cfg_accept) begin
			unique case (cfg_index)
				CFG_THRESHOLD: threshold_q <= cfg_data[AMP_BITS-1:0];
				CFG_TOLERANCE: tolerance_q <= cfg_data[TOL_BITS-1:0];
				default: ;
			endcase
		end
	end

	spv_peak_trk u_trk (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (in_accept),
		.bin       (BIN_BITS'(bin_index)),
		.amp       (amplitude),
		.last      (last_bin),
		.threshold (threshold_q),
		.peak      (trk_peak)
	);

	spv_hist_mem u_mem (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (hist_wr),
		.wr_addr   (wp_q),
		.wr_data   (trk_peak),
		.rd_req    (rd_req),
		.rd_data_a (rd_data_a),
		.rd_data_b (rd_data_b)
	);

	spv_vote_seq u_vote (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (vote_start),
		.base      (wp_next),
		.tolerance (tolerance_q),
		.rd_req    (rd_req),
		.rd_data_a (rd_data_a),
		.rd_data_b (rd_data_b),
		.res       (vote_res)
	);

	// sequence frame close, vote and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			wp_q          <= '0;
			peak_q        <= '0;
			res_ready_q   <= 1'b0;
			out_valid_q   <= 1'b0;
			peak_bin      <= '0;
			consensus_bin <= '0;
			agree_count   <= '0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (vote_res.done) begin
				res_ready_q <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_accept && last_bin) begin
						state_q <= ST_CLOSE;
					end
				end
				ST_CLOSE: begin
					peak_q  <= trk_peak;
					wp_q    <= wp_next;
					state_q <= ST_VOTE;
				end
				ST_VOTE: begin
					if (res_ready_q && (!out_valid_q || !out_stall)) begin
						res_ready_q   <= 1'b0;
						out_valid_q   <= 1'b1;
						peak_bin      <= BIN_IN_BITS'(peak_q);
						consensus_bin <= BIN_IN_BITS'(vote_res.bin);
						agree_count   <= AGREE_BITS'(vote_res.count);
						state_q       <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// history write never overlaps a running vote
	assert property (@(posedge clk) disable iff (!arst_n)
		!(hist_wr && vote_res.busy))
		else $error("history written during vote");

	// a vote result follows only a running vote
	assert property (@(posedge clk) disable iff (!arst_n)
		vote_res.done |-> $past(vote_res.busy))
		else $error("vote done without a running vote");

	// no agreement means the consensus stays at bin zero
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (agree_count == '0)) |-> (consensus_bin == '0))
		else $error("consensus set without agreement");

	// agreement count never exceeds the history depth
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (agree_count <= AGREE_BITS'(HIST_DEPTH)))
		else $error("agreement count out of range");

endmodule

`default_nettype wire

@@ sim/spectral_peak_pitch_voter_tb.sv @@
`timescale 1ns / 1ps

module spectral_peak_pitch_voter_tb;
	import spv_pkg::*;

	localparam int ITEM_TARGET = 1300;
	// quiet time after the last result: one full vote plus margin
	localparam int SETTLE = HIST_DEPTH * HIST_DEPTH + 40;
	// spare register indexes, written to show they change nothing
	localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_A = CFG_IDX_BITS'(2);
	localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_B = CFG_IDX_BITS'(3);

	typedef enum logic [1:0] {REQ_BIN, REQ_CFG, REQ_DRAIN} req_kind_e;

	typedef struct packed {
		req_kind_e                kind;
		logic [BIN_IN_BITS-1:0]   bin;
		logic [AMP_BITS-1:0]      amp;
		logic                     last;
		logic [CFG_IDX_BITS-1:0]  idx;
		logic [CFG_DAT_BITS-1:0]  data;
		logic [7:0]               gap;
		logic                     calm;
	} bin_req_t;

	typedef struct packed {
		logic [BIN_IN_BITS-1:0] peak;
		logic [BIN_IN_BITS-1:0] cons;
		logic [AGREE_BITS-1:0]  agree;
	} frame_res_t;

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [CFG_DAT_BITS-1:0] cfg_data;
	logic                    in_valid;
	logic                    in_stall;
	logic [BIN_IN_BITS-1:0]  bin_index;
	logic [AMP_BITS-1:0]     amplitude;
	logic                    last_bin;
	logic                    out_valid;
	logic                    out_stall;
	logic [BIN_IN_BITS-1:0]  peak_bin;
	logic [BIN_IN_BITS-1:0]  consensus_bin;
	logic [AGREE_BITS-1:0]   agree_count;

	spectral_peak_pitch_voter u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.bin_index     (bin_index),
		.amplitude     (amplitude),
		.last_bin      (last_bin),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.peak_bin      (peak_bin),
		.consensus_bin (consensus_bin),
		.agree_count   (agree_count)
	);

	bin_req_t   pending_q[$];
	frame_res_t frame_q[$];
	int         mismatch_cnt = 0;
	int         n_items = 0;
	bit         calm_phase = 0;

	// predictor state
	logic [AMP_BITS-1:0]    thr_m = THRESHOLD_RST;
	logic [TOL_BITS-1:0]    tol_m = TOLERANCE_RST;
	logic [BIN_IN_BITS-1:0] run_bin = '0;
	logic [AMP_BITS-1:0]    run_lvl = '0;
	bit                     in_frame = 0;
	logic [BIN_BITS-1:0]    hist[HIST_DEPTH];

	always #2 clk = ~clk;

	// idle length: mostly short, now and then long
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return $urandom_range(1, 3);
		if (r < 92)
			return $urandom_range(4, 8);
		return $urandom_range(20, 60);
	endfunction

	function automatic void push_bin(logic [BIN_IN_BITS-1:0] b, logic [AMP_BITS-1:0] a,
			logic l);
		bin_req_t q;
		q = '0;
		q.kind = REQ_BIN;
		q.bin  = b;
		q.amp  = a;
		q.last = l;
		q.calm = calm_phase;
		if (!calm_phase && $urandom_range(0, 1) == 0)
			q.gap = 8'(idle_len());
		pending_q.insert(pending_q.size(), q);
		n_items++;
	endfunction

	function automatic void push_cfg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DAT_BITS-1:0] d);
		bin_req_t q;
		q = '0;
		q.kind = REQ_CFG;
		q.idx  = idx;
		q.data = d;
		pending_q.insert(pending_q.size(), q);
	endfunction

	function automatic void push_drain();
		bin_req_t q;
		q = '0;
		q.kind = REQ_DRAIN;
		pending_q.insert(pending_q.size(), q);
	endfunction

	function automatic void note_error(string msg);
		mismatch_cnt++;
		if (mismatch_cnt <= 10)
			$display("%0t: %s", $realtime, msg);
	endfunction

	// vote over the history: oldest entry with the highest agreement wins
	function automatic void vote_history(output logic [BIN_IN_BITS-1:0] winner,
			output logic [AGREE_BITS-1:0] votes);
		logic [BIN_BITS-1:0] d;
		int n;
		winner = '0;
		votes  = '0;
		for (int a = 0; a < HIST_DEPTH; a++) begin
			n = 0;
			for (int b = 0; b < HIST_DEPTH; b++) begin
				d = (hist[a] > hist[b]) ? hist[a] - hist[b] : hist[b] - hist[a];
				if (d < tol_m)
					n++;
			end
			if (n > votes) begin
				votes  = AGREE_BITS'(n);
				winner = hist[a];
			end
		end
	endfunction

	// fold one bin into the running peak; close the frame on the last bin
	function automatic void fold_bin(logic [BIN_IN_BITS-1:0] b, logic [AMP_BITS-1:0] a,
			logic l);
		frame_res_t r;
		logic [BIN_IN_BITS-1:0] w;
		logic [AGREE_BITS-1:0] v;
		if (!in_frame || a > run_lvl) begin
			run_bin = b;
			run_lvl = a;
		end
		in_frame = 1;
		if (l) begin
			r.peak = (run_lvl < thr_m) ? '0 : run_bin;
			for (int i = 0; i + 1 < HIST_DEPTH; i++)
				hist[i] = hist[i + 1];
			hist[HIST_DEPTH - 1] = r.peak;
			in_frame = 0;
			vote_history(w, v);
			r.cons  = w;
			r.agree = v;
			frame_q.insert(frame_q.size(), r);
		end
	endfunction

	function automatic void apply_cfg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DAT_BITS-1:0] d);
		if (idx == CFG_THRESHOLD)
			thr_m = d[AMP_BITS-1:0];
		else if (idx == CFG_TOLERANCE)
			tol_m = d[TOL_BITS-1:0];
	endfunction

	function automatic void check_frame();
		frame_res_t e;
		if (frame_q.size() == 0) begin
			note_error($sformatf("unexpected result peak=%0d cons=%0d agree=%0d",
				peak_bin, consensus_bin, agree_count));
		end else begin
			e = frame_q.pop_front();
			if (e.peak !== peak_bin || e.cons !== consensus_bin || e.agree !== agree_count)
				note_error($sformatf({"mismatch expected peak=%0d cons=%0d agree=%0d",
					" got peak=%0d cons=%0d agree=%0d"}, e.peak, e.cons, e.agree,
					peak_bin, consensus_bin, agree_count));
		end
	endfunction

	// sample handshakes, predict and check
	logic in_fire = 0;
	logic cfg_fire = 0;

	always @(posedge clk) begin
		in_fire  <= in_valid && !in_stall;
		cfg_fire <= cfg_valid && cfg_ready;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				apply_cfg(cfg_index, cfg_data);
			if (in_valid && !in_stall)
				fold_bin(bin_index, amplitude, last_bin);
			if (out_valid && !out_stall)
				check_frame();
		end
	end

	// request driver: pop pending items, hold each until taken
	bin_req_t head;
	logic     in_v_nxt;
	logic     cfg_v_nxt;
	int       gap_left = 0;
	int       settle_cnt = 0;
	logic     calm_r = 0;

	always @(negedge clk) begin
		if (arst_n) begin
			in_v_nxt  = in_valid && !in_fire;
			cfg_v_nxt = cfg_valid && !cfg_fire;
			if (!in_v_nxt && !cfg_v_nxt) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_q.size() != 0) begin
					head = pending_q[0];
					case (head.kind)
						REQ_BIN: begin
							void'(pending_q.pop_front());
							bin_index <= head.bin;
							amplitude <= head.amp;
							last_bin  <= head.last;
							calm_r    <= head.calm;
							gap_left  = head.gap;
							in_v_nxt  = 1;
						end
						REQ_CFG: begin
							void'(pending_q.pop_front());
							cfg_index <= head.idx;
							cfg_data  <= head.data;
							cfg_v_nxt = 1;
						end
						default: begin
							// hold until all results are in and the block has settled
							if (frame_q.size() != 0) begin
								settle_cnt = 0;
							end else if (settle_cnt < SETTLE) begin
								settle_cnt++;
							end else begin
								void'(pending_q.pop_front());
								settle_cnt = 0;
							end
						end
					endcase
				end
			end
			in_valid  <= in_v_nxt;
			cfg_valid <= cfg_v_nxt;
		end
	end

	// result back-pressure in random bursts
	int stall_run = 0;

	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_run > 0) begin
				stall_run--;
			end else if (calm_r || $urandom_range(0, 2) != 0) begin
				out_stall <= 0;
				stall_run = $urandom_range(0, 30);
			end else begin
				out_stall <= 1;
				stall_run = idle_len();
			end
		end
	end

	initial begin
		#10ms;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		int len;
		int tone_pos;
		int frames;
		int r;
		logic [BIN_IN_BITS-1:0] pitch;
		logic [BIN_IN_BITS-1:0] base;
		logic [BIN_IN_BITS-1:0] b;
		logic [AMP_BITS-1:0]    a;
		logic [AMP_BITS-1:0]    prev_a;
		logic [AMP_BITS-1:0]    thr;
		logic [TOL_BITS-1:0]    tol;

		clk       = 0;
		arst_n    = 0;
		cfg_valid = 0;
		cfg_index = '0;
		cfg_data  = '0;
		in_valid  = 0;
		bin_index = '0;
		amplitude = '0;
		last_bin  = 0;
		out_stall = 0;
		foreach (hist[i])
			hist[i] = '0;

		// reset settings: single-bin frame, tie, late peak, threshold edges
		push_bin(12'd5, 24'hFFFFFF, 1);
		push_bin(12'd10, 24'd1000, 0);
		push_bin(12'd20, 24'd1000, 1);
		push_bin(12'd30, 24'd500, 0);
		push_bin(12'd31, 24'd400, 0);
		push_bin(12'd32, 24'd600, 1);
		push_bin(12'd7, THRESHOLD_RST - 24'd1, 1);
		push_bin(12'd8, THRESHOLD_RST, 1);
		push_bin(12'd4095, 24'hFFFFFF, 1);
		push_bin(12'd0, 24'd0, 0);
		push_bin(12'd4095, 24'd0, 1);
		push_bin(12'd9, 24'd460, 1);
		push_bin(12'd10, 24'd500, 1);

		// zero tolerance: nothing agrees
		push_drain();
		push_cfg(CFG_TOLERANCE, 24'd0);
		push_bin(12'd100, 24'd2000, 1);
		push_bin(12'd100, 24'd2000, 1);

		// widest tolerance, top threshold, upper data bits set
		push_drain();
		push_cfg(CFG_THRESHOLD, 24'hFFFFFF);
		push_cfg(CFG_TOLERANCE, 24'hFFFFFF);
		push_bin(12'd1, 24'hFFFFFE, 1);
		push_bin(12'd2, 24'hFFFFFF, 1);
		push_bin(12'd4095, 24'hFFFFFF, 1);

		// zero threshold, spare indexes
		push_drain();
		push_cfg(CFG_THRESHOLD, 24'd0);
		push_cfg(CFG_SPARE_A, 24'hABCDEF);
		push_cfg(CFG_SPARE_B, 24'h123456);
		push_bin(12'd0, 24'd0, 1);
		push_bin(12'd3, 24'd0, 0);
		push_bin(12'd4, 24'd1, 1);

		// random phases of frames around a pitch
		while (n_items < ITEM_TARGET) begin
			push_drain();
			calm_phase = 0;
			r = $urandom_range(0, 7);
			case (r)
				0: thr = '0;
				1: thr = '1;
				2: thr = THRESHOLD_RST;
				3: thr = AMP_BITS'($urandom);
				default: thr = AMP_BITS'($urandom_range(0, 24'h0FFFFF));
			endcase
			r = $urandom_range(0, 7);
			case (r)
				0: tol = '0;
				1: tol = '1;
				2: tol = TOLERANCE_RST;
				default: tol = TOL_BITS'($urandom_range(1, 40));
			endcase
			push_cfg(CFG_THRESHOLD, thr);
			push_cfg(CFG_TOLERANCE, {12'($urandom), tol});
			calm_phase = ($urandom_range(0, 3) == 0);
			pitch  = BIN_IN_BITS'($urandom);
			frames = $urandom_range(15, 40);
			for (int f = 0; f < frames && n_items < ITEM_TARGET; f++) begin
				r = $urandom_range(0, 99);
				if (r < 70)
					len = $urandom_range(1, 6);
				else if (r < 95)
					len = $urandom_range(7, 20);
				else
					len = $urandom_range(21, 60);
				base     = BIN_IN_BITS'($urandom);
				tone_pos = ($urandom_range(0, 9) < 7) ? $urandom_range(0, len - 1) : -1;
				prev_a   = '0;
				for (int k = 0; k < len; k++) begin
					b = base + BIN_IN_BITS'(k);
					r = $urandom_range(0, 9);
					if (k == tone_pos) begin
						b = pitch + BIN_IN_BITS'($urandom_range(0, 6)) - 12'd3;
						a = 24'hF00000 | AMP_BITS'($urandom_range(0, 24'h0FFFFF));
					end else if (r < 5) begin
						a = AMP_BITS'($urandom);
					end else if (r < 8 || k == 0) begin
						a = AMP_BITS'($urandom_range(0, 1023));
					end else begin
						a = prev_a;
					end
					prev_a = a;
					push_bin(b, a, k == len - 1);
				end
				// pause the sender now and then until every result is back
				if ($urandom_range(0, 11) == 0)
					push_drain();
			end
		end

		repeat (6) @(negedge clk);
		arst_n <= 1;

		while (pending_q.size() != 0 || in_valid || cfg_valid)
			@(posedge clk);
		while (frame_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);

		if (mismatch_cnt == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

@@ filelist.f @@
src/spv_pkg.sv
src/spv_peak_trk.sv
src/spv_hist_mem.sv
src/spv_vote_seq.sv
src/spectral_peak_pitch_voter.sv
sim/spectral_peak_pitch_voter_tb.sv
